[design/nlod_pkg.sv]
// Package for the nested level to offsets decoder.
// Holds the word types, register indexes and counter helpers.
// No dependencies.
package nlod_pkg;

	localparam int COUNT_BITS = 31;
	localparam int OUT_W      = 31;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DEF = 1'b0,
		REG_MAX_REP = 1'b1
	} reg_idx_t;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] def_level;
		logic [LEVEL_W-1:0] rep_level;
		logic               first_item;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] start_offset;
		logic [OUT_W-1:0] entry_count;
		logic             is_null;
		logic             batch_end;
		logic             run_last;
	} rec_t;

	function automatic count_t sat_inc(input count_t c);
		sat_inc = (c == CNT_MAX) ? c : c + count_t'(1);
	endfunction

	function automatic rec_t make_rec(input count_t start, input count_t cnt,
			input logic null_flag, input logic end_flag, input logic last_flag);
		rec_t r;
		count_t diff;
		diff = cnt - start;
		r.start_offset = OUT_W'(start);
		r.entry_count  = OUT_W'(diff);
		r.is_null      = null_flag;
		r.batch_end    = end_flag;
		r.run_last     = last_flag;
		make_rec = r;
	endfunction

endpackage

[design/nested_level_to_offsets_decoder.sv]
// Nested level to offsets decoder: turns level pairs into collection records; uses nlod_pkg.
// Path: a word is captured in the input register, decoded from there, and its records
// are written into the output queue, whose head drives the output.
// Throughput: one word per cycle while the output queue holds at most two records; a word
// that yields two records is absorbed by the four-entry queue, which stalls input above two.
// Reset clears the state and the queue and sets both level registers to 1.
module nested_level_to_offsets_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  nlod_pkg::item_t                  item,
	output logic                             rec_valid,
	input  logic                             rec_stall,
	output nlod_pkg::rec_t                   rec,
	input  logic                             wr_en,
	input  logic [nlod_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [nlod_pkg::CFG_DATA_W-1:0]  wr_data
);

	logic [nlod_pkg::LEVEL_W-1:0] max_def_q, max_rep_q;

	logic            valid_s1;
	nlod_pkg::item_t item_s1;

	nlod_pkg::count_t counter_q, start_q;
	logic             last_null_q, open_null_q;

	nlod_pkg::rec_t                  fifo_q [nlod_pkg::FIFO_DEPTH];
	logic [nlod_pkg::PTR_W-1:0]      rd_ptr_q, wr_ptr_q;
	logic [nlod_pkg::FILL_W-1:0]     fill_q;

	logic advance, pop;
	logic has_md, empty, is_null;
	logic coll_begin, entry_begin;
	logic emit0, emit1;
	nlod_pkg::count_t cnt_a, cnt_b, start_n;
	logic             last_null_n, open_null_n;
	nlod_pkg::rec_t   rec0, rec1;
	logic [nlod_pkg::FILL_W-1:0] n_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_def_q <= nlod_pkg::LEVEL_W'(1);
			max_rep_q <= nlod_pkg::LEVEL_W'(1);
		end else if (wr_en) begin
			unique case (nlod_pkg::reg_idx_t'(wr_index))
				nlod_pkg::REG_MAX_DEF: max_def_q <= wr_data;
				nlod_pkg::REG_MAX_REP: max_rep_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (fill_q <= nlod_pkg::FILL_W'(nlod_pkg::FIFO_DEPTH - 2));
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		has_md      = max_def_q != '0;
		empty       = has_md && (item_s1.def_level < max_def_q - nlod_pkg::LEVEL_W'(1));
		is_null     = has_md && (item_s1.def_level == max_def_q - nlod_pkg::LEVEL_W'(1));
		coll_begin  = (item_s1.rep_level < max_rep_q) && !empty;
		entry_begin = (item_s1.rep_level <= max_rep_q) && !empty;

		if (item_s1.first_item) begin
			cnt_a       = '0;
			start_n     = '0;
			last_null_n = is_null;
			open_null_n = is_null;
			emit0       = 1'b0;
		end else begin
			cnt_a       = (entry_begin && !last_null_q) ? nlod_pkg::sat_inc(counter_q)
			                                            : counter_q;
			start_n     = coll_begin ? cnt_a : start_q;
			open_null_n = coll_begin ? is_null : open_null_q;
			last_null_n = empty ? last_null_q : is_null;
			emit0       = coll_begin;
		end

		emit1 = item_s1.last_item;
		cnt_b = (emit1 && !last_null_n) ? nlod_pkg::sat_inc(cnt_a) : cnt_a;

		rec0 = nlod_pkg::make_rec(start_q, cnt_a, open_null_q, 1'b0, !emit1);
		rec1 = nlod_pkg::make_rec(start_n, cnt_b, open_null_n, 1'b1, 1'b1);

		n_push = nlod_pkg::FILL_W'(emit0) + nlod_pkg::FILL_W'(emit1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q   <= '0;
			start_q     <= '0;
			last_null_q <= 1'b0;
			open_null_q <= 1'b0;
		end else if (advance) begin
			counter_q   <= cnt_b;
			start_q     <= start_n;
			last_null_q <= last_null_n;
			open_null_q <= open_null_n;
		end
	end

	assign pop       = rec_valid && !rec_stall;
	assign rec_valid = fill_q != '0;
	assign rec       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (advance) begin
			if (emit0) begin
				fifo_q[wr_ptr_q] <= rec0;
			end
			if (emit1) begin
				fifo_q[wr_ptr_q + nlod_pkg::PTR_W'(emit0)] <= rec1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + nlod_pkg::PTR_W'(1);
			end
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + nlod_pkg::PTR_W'(n_push);
			end
			fill_q <= fill_q + (advance ? n_push : '0) - nlod_pkg::FILL_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= nlod_pkg::FILL_W'(nlod_pkg::FIFO_DEPTH))
		else $error("output queue overfilled");

	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.first_item && !item_s1.last_item)
		|=> (fill_q == $past(fill_q) - nlod_pkg::FILL_W'($past(pop))))
		else $error("first word of a batch produced a record");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_item) |=> (fill_q != '0))
		else $error("last word of a batch gave no flush record");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == nlod_pkg::PTR_W'(fill_q))
		else $error("queue pointers disagree with fill count");
`endif

endmodule
